// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the instruction execute core.
// Each macro wraps one concurrent assertion clocked on a rising edge and
// disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/c8ex_pkg.sv =====
// Package of the instruction execute core: widths, reset values, opcode
// groups, arithmetic opcodes, status codes and the result and control structs.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package c8ex_pkg;

  localparam int ADDR_W = 12;
  localparam int BYTE_W = 8;
  localparam int NIB_W = 4;
  localparam int INSTR_W = 16;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 48;
  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [ADDR_W-1:0] START_PC = 12'h200;
  localparam logic [ADDR_W-1:0] PC_STEP = 12'd2;
  localparam logic [NIB_W-1:0] FLAG_REG = 4'hF;
  localparam logic [NIB_W-1:0] BASE_REG = 4'h0;

  localparam logic [INSTR_W-1:0] INSTR_CLS = 16'h00E0;
  localparam logic [INSTR_W-1:0] INSTR_RET = 16'h00EE;

  typedef enum logic [NIB_W-1:0] {
    GRP_SYS    = 4'h0,
    GRP_JP     = 4'h1,
    GRP_CALL   = 4'h2,
    GRP_SE_K   = 4'h3,
    GRP_SNE_K  = 4'h4,
    GRP_SE_R   = 4'h5,
    GRP_LD_K   = 4'h6,
    GRP_ADD_K  = 4'h7,
    GRP_ALU    = 4'h8,
    GRP_SNE_R  = 4'h9,
    GRP_LD_I   = 4'hA,
    GRP_JP_V0  = 4'hB,
    GRP_RND    = 4'hC,
    GRP_DRAW   = 4'hD,
    GRP_KEY    = 4'hE,
    GRP_MISC   = 4'hF
  } group_t;

  localparam logic [NIB_W-1:0] ALU_MOV  = 4'h0;
  localparam logic [NIB_W-1:0] ALU_OR   = 4'h1;
  localparam logic [NIB_W-1:0] ALU_AND  = 4'h2;
  localparam logic [NIB_W-1:0] ALU_XOR  = 4'h3;
  localparam logic [NIB_W-1:0] ALU_ADD  = 4'h4;
  localparam logic [NIB_W-1:0] ALU_SUB  = 4'h5;
  localparam logic [NIB_W-1:0] ALU_SHR  = 4'h6;
  localparam logic [NIB_W-1:0] ALU_SUBN = 4'h7;
  localparam logic [NIB_W-1:0] ALU_SHL  = 4'hE;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_OVERFLOW    = 2'd1,
    ST_UNDERFLOW   = 2'd2,
    ST_UNSUPPORTED = 2'd3
  } status_t;

  // Packed so that next_pc sits in the lowest bits, matching the stream layout.
  typedef struct packed {
    status_t           status;
    logic              clear_screen;
    logic [BYTE_W-1:0] flag_value;
    logic [BYTE_W-1:0] reg_value;
    logic [NIB_W-1:0]  reg_dest;
    logic              reg_write;
    logic [ADDR_W-1:0] index_value;
    logic [ADDR_W-1:0] next_pc;
  } result_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [ADDR_W-1:0] ret_addr;
  } stack_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/c8ex_exec.sv =====
// Combinational execute logic for one instruction: decode, register
// arithmetic, flags, branch and stack control. Depends on c8ex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c8ex_exec
  import c8ex_pkg::*;
(
  input  wire logic [INSTR_W-1:0] instr_word,
  input  wire logic [BYTE_W-1:0]  random_byte,
  input  wire logic [BYTE_W-1:0]  vx,
  input  wire logic [BYTE_W-1:0]  vy,
  input  wire logic [BYTE_W-1:0]  v0,
  input  wire logic [BYTE_W-1:0]  vf,
  input  wire logic [ADDR_W-1:0]  pc,
  input  wire logic [ADDR_W-1:0]  index_reg,
  input  wire logic [ADDR_W-1:0]  stack_top,
  input  wire logic               stack_full,
  input  wire logic               stack_empty,
  output result_t                 res,
  output stack_ctl_t              ctl
);

  group_t            grp;
  logic [NIB_W-1:0]  x;
  logic [NIB_W-1:0]  low;
  logic [BYTE_W-1:0] kk;
  logic [ADDR_W-1:0] nnn;
  logic [ADDR_W-1:0] pc_adv;
  logic [ADDR_W-1:0] pc_out;
  logic [ADDR_W-1:0] idx_out;
  logic [BYTE_W:0]   sum;
  logic              wr;
  logic [BYTE_W-1:0] val;
  logic              flag_wr;
  logic              flag_bit;
  logic              clr;
  logic              skip;
  logic              push;
  logic              pop;
  status_t           status;

  assign grp = group_t'(instr_word[15:12]);
  assign x = instr_word[11:8];
  assign low = instr_word[3:0];
  assign kk = instr_word[7:0];
  assign nnn = instr_word[11:0];
  assign pc_adv = pc + PC_STEP;
  assign sum = {1'b0, vx} + {1'b0, vy};

  always_comb begin
    pc_out = pc_adv;
    idx_out = index_reg;
    wr = 1'b0;
    val = '0;
    flag_wr = 1'b0;
    flag_bit = 1'b0;
    clr = 1'b0;
    skip = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    status = ST_OK;
    unique case (grp)
      GRP_SYS: begin
        if (instr_word == INSTR_CLS) begin
          clr = 1'b1;
        end else if (instr_word == INSTR_RET) begin
          if (stack_empty) begin
            status = ST_UNDERFLOW;
          end else begin
            pop = 1'b1;
            pc_out = stack_top;
          end
        end else begin
          status = ST_UNSUPPORTED;
        end
      end
      GRP_JP: pc_out = nnn;
      GRP_CALL: begin
        if (stack_full) begin
          status = ST_OVERFLOW;
        end else begin
          push = 1'b1;
          pc_out = nnn;
        end
      end
      GRP_SE_K:  skip = (vx == kk);
      GRP_SNE_K: skip = (vx != kk);
      GRP_SE_R:  skip = (vx == vy);
      GRP_LD_K: begin
        wr = 1'b1;
        val = kk;
      end
      GRP_ADD_K: begin
        wr = 1'b1;
        val = vx + kk;
      end
      GRP_ALU: begin
        wr = 1'b1;
        unique case (low)
          ALU_MOV: val = vy;
          ALU_OR:  val = vx | vy;
          ALU_AND: val = vx & vy;
          ALU_XOR: val = vx ^ vy;
          ALU_ADD: begin
            flag_wr = 1'b1;
            flag_bit = sum[BYTE_W];
            val = sum[BYTE_W-1:0];
          end
          ALU_SUB: begin
            flag_wr = 1'b1;
            flag_bit = (vx > vy);
            val = vx - vy;
          end
          ALU_SHR: begin
            flag_wr = 1'b1;
            flag_bit = vx[0];
            val = {1'b0, vx[BYTE_W-1:1]};
          end
          ALU_SUBN: begin
            flag_wr = 1'b1;
            flag_bit = (vy > vx);
            val = vy - vx;
          end
          ALU_SHL: begin
            flag_wr = 1'b1;
            flag_bit = vx[BYTE_W-1];
            val = {vx[BYTE_W-2:0], 1'b0};
          end
          default: begin
            wr = 1'b0;
            status = ST_UNSUPPORTED;
          end
        endcase
      end
      GRP_SNE_R: skip = (vx != vy);
      GRP_LD_I:  idx_out = nnn;
      GRP_JP_V0: pc_out = nnn + {{(ADDR_W-BYTE_W){1'b0}}, v0};
      GRP_RND: begin
        wr = 1'b1;
        val = random_byte & kk;
      end
      GRP_DRAW, GRP_KEY, GRP_MISC: status = ST_UNSUPPORTED;
      default: status = ST_UNSUPPORTED;
    endcase
    if (skip) begin
      pc_out = pc_adv + PC_STEP;
    end
  end

  always_comb begin
    res.next_pc = pc_out;
    res.index_value = idx_out;
    res.reg_write = wr;
    res.reg_dest = wr ? x : '0;
    res.reg_value = wr ? val : '0;
    priority if (wr && (x == FLAG_REG)) begin
      res.flag_value = val;
    end else if (flag_wr) begin
      res.flag_value = {{(BYTE_W-1){1'b0}}, flag_bit};
    end else begin
      res.flag_value = vf;
    end
    res.clear_screen = clr;
    res.status = status;
    ctl.push = push;
    ctl.pop = pop;
    ctl.ret_addr = pc_adv;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/chip8_instruction_execute_core.sv =====
// Instruction execute core: one result transfer for every instruction transfer, one
// instruction a cycle sustained while the result output is not stalled. An
// input register holds the instruction while the register file is read, a single
// execute pass turns it into a result register, and the architectural state (V0..VF,
// program counter, index register, return stack) updates at the same edge, so the
// next instruction follows directly. Depends on c8ex_pkg, c8ex_exec and the
// assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module chip8_instruction_execute_core
  import c8ex_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // Fields from bit 0: instr_word[15:0], random_byte[23:16].
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // Fields from bit 0: next_pc[11:0], index_value[23:12], reg_write[24],
  // reg_dest[28:25], reg_value[36:29], flag_value[44:37], clear_screen[45],
  // status[47:46].
  output      logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = $clog2(STACK_DEPTH);
  localparam int NREGS = 2 ** NIB_W;

  logic                  in_valid;
  logic [INSTR_W-1:0]    word_q;
  logic [BYTE_W-1:0]     rnd_q;
  logic                  out_valid;
  result_t               out_q;
  logic                  in_fire;
  logic                  exec_fire;
  logic                  exec_wr;

  logic [BYTE_W-1:0]     rf_mem [NREGS];
  logic [NREGS-1:0]      rf_valid;
  logic [BYTE_W-1:0]     rd_x;
  logic [BYTE_W-1:0]     rd_y;
  logic                  vld_x;
  logic                  vld_y;
  logic                  byp_x;
  logic                  byp_y;
  logic [BYTE_W-1:0]     byp_val;
  logic [BYTE_W-1:0]     vf;
  logic [BYTE_W-1:0]     v0;
  logic [BYTE_W-1:0]     vx_mem;
  logic [BYTE_W-1:0]     vy_mem;
  logic [BYTE_W-1:0]     vx;
  logic [BYTE_W-1:0]     vy;
  logic [NIB_W-1:0]      x_in;
  logic [NIB_W-1:0]      y_in;
  logic [NIB_W-1:0]      x_q;
  logic [NIB_W-1:0]      y_q;

  logic [ADDR_W-1:0]     pc;
  logic [ADDR_W-1:0]     index_reg;
  logic [SP_W-1:0]       sp;
  logic [SP_W-1:0]       sp_next;
  logic [SP_W-1:0]       sp_dec;
  logic [IDX_W-1:0]      st_rd_addr;
  logic [ADDR_W-1:0]     st_mem [STACK_DEPTH];
  logic [ADDR_W-1:0]     st_rd;
  logic                  top_byp;
  logic [ADDR_W-1:0]     push_val;
  logic [ADDR_W-1:0]     stack_top;
  logic                  stack_full;
  logic                  stack_empty;
  logic                  do_push;
  logic                  do_pop;

  result_t               res;
  stack_ctl_t            ctl;

  assign exec_fire = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || exec_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign exec_wr = exec_fire && res.reg_write;
  assign do_push = exec_fire && ctl.push;
  assign do_pop = exec_fire && ctl.pop;

  assign x_in = s_axis_tdata[11:8];
  assign y_in = s_axis_tdata[7:4];
  assign x_q = word_q[11:8];
  assign y_q = word_q[7:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid <= 1'b1;
      end else if (exec_fire) begin
        in_valid <= 1'b0;
      end
      if (exec_fire) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      word_q <= s_axis_tdata[INSTR_W-1:0];
      rnd_q <= s_axis_tdata[INSTR_W+BYTE_W-1:INSTR_W];
    end
    if (exec_fire) begin
      out_q <= res;
    end
  end

  // Register file: read as the instruction is captured, with the write of the
  // instruction executing at the same edge forwarded around the array.
  always_ff @(posedge clk) begin
    if (exec_wr) begin
      rf_mem[res.reg_dest] <= res.reg_value;
    end
    if (in_fire) begin
      rd_x <= rf_mem[x_in];
      rd_y <= rf_mem[y_in];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      vld_x <= 1'b0;
      vld_y <= 1'b0;
      byp_x <= 1'b0;
      byp_y <= 1'b0;
      vf <= '0;
      v0 <= '0;
      pc <= START_PC;
      index_reg <= '0;
      sp <= '0;
      top_byp <= 1'b0;
    end else begin
      if (exec_wr) begin
        rf_valid[res.reg_dest] <= 1'b1;
      end
      if (in_fire) begin
        vld_x <= rf_valid[x_in];
        vld_y <= rf_valid[y_in];
        byp_x <= exec_wr && (res.reg_dest == x_in);
        byp_y <= exec_wr && (res.reg_dest == y_in);
      end
      if (exec_fire) begin
        vf <= res.flag_value;
        pc <= res.next_pc;
        index_reg <= res.index_value;
        if (res.reg_write && (res.reg_dest == BASE_REG)) begin
          v0 <= res.reg_value;
        end
      end
      sp <= sp_next;
      top_byp <= do_push;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byp_val <= res.reg_value;
    end
  end

  assign vx_mem = byp_x ? byp_val : (vld_x ? rd_x : '0);
  assign vy_mem = byp_y ? byp_val : (vld_y ? rd_y : '0);
  assign vx = (x_q == FLAG_REG) ? vf : vx_mem;
  assign vy = (y_q == FLAG_REG) ? vf : vy_mem;

  // Return stack: the top entry is read ahead from the next stack pointer; a push
  // in the cycle before is taken from the bypass register.
  always_comb begin
    sp_next = sp;
    if (do_push) begin
      sp_next = sp + SP_W'(1);
    end else if (do_pop) begin
      sp_next = sp - SP_W'(1);
    end
    sp_dec = sp_next - SP_W'(1);
    st_rd_addr = (sp_next == '0) ? '0 : sp_dec[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      st_mem[sp[IDX_W-1:0]] <= ctl.ret_addr;
      push_val <= ctl.ret_addr;
    end
    st_rd <= st_mem[st_rd_addr];
  end

  assign stack_top = top_byp ? push_val : st_rd;
  assign stack_full = (sp == SP_W'(STACK_DEPTH));
  assign stack_empty = (sp == '0);

  c8ex_exec u_exec (
    .instr_word  (word_q),
    .random_byte (rnd_q),
    .vx          (vx),
    .vy          (vy),
    .v0          (v0),
    .vf          (vf),
    .pc          (pc),
    .index_reg   (index_reg),
    .stack_top   (stack_top),
    .stack_full  (stack_full),
    .stack_empty (stack_empty),
    .res         (res),
    .ctl         (ctl)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_q;

  `ASSERT_ALWAYS(a_sp_range, clk, rst, sp <= SP_W'(STACK_DEPTH), "stack pointer past depth")
  `ASSERT_ALWAYS(a_push_pop, clk, rst, !(ctl.push && ctl.pop), "push and pop together")
  `ASSERT_IMPLY(a_overflow, clk, rst, exec_fire && (res.status == ST_OVERFLOW), stack_full, "overflow without full stack")
  `ASSERT_NEXT(a_push_sp, clk, rst, do_push, sp == $past(sp) + SP_W'(1), "push did not advance stack pointer")
  `ASSERT_NEXT(a_exec_out, clk, rst, exec_fire, out_valid, "executed instruction gave no result")

endmodule

`default_nettype wire
